// File: design/box_blur_3x3_unit_defines.svh
// assertion macros for the box blur unit
`ifndef BOX_BLUR_3X3_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BB3_ASSERT_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bb3 assertion failed");
`define BB3_ASSERT_CLK(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("bb3 assertion failed");
`else
`define BB3_ASSERT_RST(name, clk, rst_n, prop)
`define BB3_ASSERT_CLK(name, clk, prop)
`endif
`endif

// File: design/bb3_pkg.sv
// shared types, constants and functions of the box blur unit
package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WIDTH_W       = 11;
  localparam int HEIGHT_W      = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int QDEPTH        = 4;
  localparam int RECIP_SHIFT   = 18;

  localparam logic [WIDTH_W-1:0]   WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET = 16'd768;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_in_run;
    logic       frame_end;
  } out_pix_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // grid index is col*3+row, col 0 = two back, row 0 = two rows up
  typedef struct packed {
    pixel_t [8:0] grid;
    logic [3:0]   mask;
    logic [1:0]   rf_a;
    logic [1:0]   rf_b;
    logic [1:0]   cf_a;
    logic [1:0]   cf_b;
  } job_t;

  // ceil(2^18 / (2n)) for the neighbour counts that occur
  function automatic logic [17:0] recip(input logic [3:0] n);
    logic [17:0] m;
    unique case (n)
      4'd1: m = 18'd131072;
      4'd2: m = 18'd65536;
      4'd3: m = 18'd43691;
      4'd4: m = 18'd32768;
      4'd6: m = 18'd21846;
      4'd9: m = 18'd14564;
      default: m = 18'd0;
    endcase
    return m;
  endfunction

endpackage

// File: design/bb3_front.sv
// front part: frame position, line store, window and job build
module bb3_front #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bb3_pkg::in_pix_t                   in_data,
  input  logic                               cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               q_full,
  output logic                               job_push,
  output bb3_pkg::job_t                      job
);
  import bb3_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CW-1:0]       col_r;
  logic [HEIGHT_W-1:0] row_r;
  logic [WW-1:0]       w_ext, eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic                last_col, last_row, accept, s1_adv;

  logic                s1_v_r;
  pixel_t              s1_px_r;
  logic [CW-1:0]       s1_col_r;
  logic                s1_ge1r_r, s1_ge2r_r, s1_ge1c_r, s1_ge2c_r, s1_lc_r, s1_lr_r;

  logic [47:0]         mem [MAX_WIDTH];
  logic [47:0]         rd_r, fwd_data_r, pair, wr_pair;
  logic                fwd_r;
  pixel_t              older, newer;
  pixel_t [2:0]        win0_r, win1_r, col2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        width_r <= cfg_data[WIDTH_W-1:0];
      end else begin
        height_r <= cfg_data[HEIGHT_W-1:0];
      end
    end
  end

  assign w_ext    = WW'(width_r);
  assign eff_w    = (width_r == '0) ? WW'(1) :
                    (w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext;
  assign eff_h    = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  assign last_col = (WW'(col_r) + WW'(1)) == eff_w;
  assign last_row = row_r == (eff_h - HEIGHT_W'(1));

  assign s1_adv   = s1_v_r && !q_full;
  assign in_stall = s1_v_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + HEIGHT_W'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= pixel_t'(in_data);
      s1_col_r  <= col_r;
      s1_ge1r_r <= row_r != '0;
      s1_ge2r_r <= row_r > HEIGHT_W'(1);
      s1_ge1c_r <= col_r != '0;
      s1_ge2c_r <= col_r > CW'(1);
      s1_lc_r   <= last_col;
      s1_lr_r   <= last_row;
    end
  end

  // line store pair: older row in the top half, newer row below
  assign pair    = fwd_r ? fwd_data_r : rd_r;
  assign older   = pixel_t'(pair[47:24]);
  assign newer   = pixel_t'(pair[23:0]);
  assign wr_pair = {newer, s1_px_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r       <= mem[col_r];
      fwd_r      <= s1_adv && (s1_col_r == col_r);
      fwd_data_r <= wr_pair;
    end
    if (s1_adv) begin
      mem[s1_col_r] <= wr_pair;
    end
  end

  assign col2 = {s1_px_r, newer, older};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win0_r <= win1_r;
      win1_r <= col2;
    end
  end

  always_comb begin
    job.grid = {col2, win1_r, win0_r};
    job.mask = {s1_lr_r && s1_lc_r, s1_lr_r && s1_ge1c_r,
                s1_ge1r_r && s1_lc_r, s1_ge1r_r && s1_ge1c_r};
    job.rf_a = s1_ge2r_r ? 2'd0 : 2'd1;
    job.rf_b = s1_ge1r_r ? 2'd1 : 2'd2;
    job.cf_a = s1_ge2c_r ? 2'd0 : 2'd1;
    job.cf_b = s1_ge1c_r ? 2'd1 : 2'd2;
  end

  assign job_push = s1_adv && (job.mask != '0);

endmodule

// File: design/bb3_queue.sv
// job queue between front and back
`include "box_blur_3x3_unit_defines.svh"
module bb3_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bb3_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_v,
  output bb3_pkg::job_t head
);
  import bb3_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t          q_r [QDEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;

  assign full   = cnt_r == (PW+1)'(QDEPTH);
  assign head_v = cnt_r != '0;
  assign head   = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_job;
    end
  end

  `BB3_ASSERT_RST(a_push_room, clk, rst_n, push |-> !full)
  `BB3_ASSERT_RST(a_pop_item, clk, rst_n, pop |-> head_v)
  `BB3_ASSERT_RST(a_cnt_bound, clk, rst_n, cnt_r <= (PW+1)'(QDEPTH))

endmodule

// File: design/bb3_back.sv
// back part: walks results of each job, sums, divides and drives the output
`include "box_blur_3x3_unit_defines.svh"
module bb3_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_v,
  input  bb3_pkg::job_t     head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output bb3_pkg::out_pix_t out_data
);
  import bb3_pkg::*;

  logic [3:0]  done_r, rem, cur;
  logic        last, issue, sum_en, out_en;
  logic [1:0]  rf, cf;
  logic [3:0]  n;
  logic [11:0] sr, sg, sb;

  logic        sum_v_r, s_last_r, s_fe_r;
  logic [11:0] s_r_r, s_g_r, s_b_r;
  logic [3:0]  s_n_r;
  logic [17:0] m;
  logic [12:0] xr, xg, xb;
  logic [30:0] pr, pg, pb;

  logic        out_v_r;
  out_pix_t    out_r;

  assign rem  = head.mask & ~done_r;
  assign cur  = rem & (~rem + 4'd1);
  assign last = (rem & ~cur) == '0;
  assign rf   = (cur[0] || cur[1]) ? head.rf_a : head.rf_b;
  assign cf   = (cur[0] || cur[2]) ? head.cf_a : head.cf_b;
  assign n    = 4'((2'd3 - rf) * (2'd3 - cf));

  assign out_en = !out_v_r || !out_stall;
  assign sum_en = !sum_v_r || out_en;
  assign issue  = head_v && sum_en;
  assign pop    = issue && last;

  always_comb begin
    sr = '0;
    sg = '0;
    sb = '0;
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        if (x >= int'(cf) && y >= int'(rf)) begin
          sr = sr + 12'(head.grid[x*3+y].r);
          sg = sg + 12'(head.grid[x*3+y].g);
          sb = sb + 12'(head.grid[x*3+y].b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      sum_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (issue) begin
        done_r <= last ? '0 : (done_r | cur);
      end
      if (sum_en) begin
        sum_v_r <= issue;
      end
      if (out_en) begin
        out_v_r <= sum_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s_r_r    <= sr;
      s_g_r    <= sg;
      s_b_r    <= sb;
      s_n_r    <= n;
      s_last_r <= last;
      s_fe_r   <= cur[3];
    end
  end

  // rounded mean (2*sum+n)/(2n) by reciprocal multiply
  assign m  = recip(s_n_r);
  assign xr = {s_r_r, 1'b0} + 13'(s_n_r);
  assign xg = {s_g_r, 1'b0} + 13'(s_n_r);
  assign xb = {s_b_r, 1'b0} + 13'(s_n_r);
  assign pr = 31'(xr) * 31'(m);
  assign pg = 31'(xg) * 31'(m);
  assign pb = 31'(xb) * 31'(m);

  always_ff @(posedge clk) begin
    if (out_en && sum_v_r) begin
      out_r.out_red     <= pr[RECIP_SHIFT+7:RECIP_SHIFT];
      out_r.out_green   <= pg[RECIP_SHIFT+7:RECIP_SHIFT];
      out_r.out_blue    <= pb[RECIP_SHIFT+7:RECIP_SHIFT];
      out_r.last_in_run <= s_last_r;
      out_r.frame_end   <= s_fe_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `BB3_ASSERT_RST(a_fe_last, clk, rst_n, out_v_r && out_r.frame_end |-> out_r.last_in_run)
  `BB3_ASSERT_RST(a_issue_some, clk, rst_n, issue |-> cur != '0)
  `BB3_ASSERT_CLK(a_rst_idle, clk, !rst_n |=> !out_v_r && !sum_v_r)

endmodule

// File: design/box_blur_3x3_unit.sv
// top level of the 3x3 box blur unit
//
// Pixels enter in raster order on the in_ channel (valid/stall) and blurred
// pixels leave on the out_ channel. Results trail the input by one row and one
// column; the last row of a frame is released by the last row's own inputs.
// Each input item causes zero to four results; last_in_run marks the last one
// of an item and frame_end the final pixel of the frame.
// From an accepted item to its first result, the line store is read at the
// accepting edge, then the job enters the job queue, the window sums are
// registered and the reciprocal multiply is registered into the output reg.
// The input takes one item per cycle while the back end keeps up; the back end
// delivers one result per cycle while out_stall is low; items at row ends and
// on the last row can cause more than one result, absorbed by a four-job queue.
// cfg_we writes frame_width (index 0) or frame_height (index 1) and restarts
// the frame; write only while the unit is idle.
// Synchronous reset sets width 1024, height 768 and an empty pipeline; the line
// store needs no clearing since only rows of the current frame enter the sums.
// When out_stall is high the output holds, the pipeline fills and in_stall rises.
module box_blur_3x3_unit #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bb3_pkg::in_pix_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bb3_pkg::out_pix_t              out_data,
  input  logic                           cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bb3_pkg::*;

  logic q_full, job_push, head_v, pop;
  job_t job, head;

  bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (job)
  );

  bb3_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .push_job(job),
    .full    (q_full),
    .pop     (pop),
    .head_v  (head_v),
    .head    (head)
  );

  bb3_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_v   (head_v),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
